>>> rtl/triangle_cull_filter_defines.svh
`ifndef TRIANGLE_CULL_FILTER_DEFINES_SVH
`define TRIANGLE_CULL_FILTER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TCF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tcf_pkg.sv
package tcf_pkg;

    localparam int DEF_VERTEX_DEPTH = 4096;
    localparam int DEF_POS_BITS     = 16;

    // fixed field widths
    localparam int SLOT_W     = 12;
    localparam int POS_IN_W   = 16;
    localparam int IDX_W      = 32;
    localparam int CNT_W      = 32;
    localparam int EPS_W      = 64;
    localparam int VC_W       = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // slave word layout
    localparam int S_TDATA_W  = 160;
    localparam int S_TUSER_W  = 1;
    localparam int S_SLOT_LSB = 0;
    localparam int S_POSX_LSB = 12;
    localparam int S_POSY_LSB = 28;
    localparam int S_POSZ_LSB = 44;
    localparam int S_IDXA_LSB = 60;
    localparam int S_IDXB_LSB = 92;
    localparam int S_IDXC_LSB = 124;

    // master word layout
    localparam int M_TDATA_W = 192;
    localparam int M_TUSER_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PRIM_MODE       = 3'd0;
    localparam t_cfg_idx CFG_VERTEX_COUNT    = 3'd1;
    localparam t_cfg_idx CFG_REMOVE_BY_INDEX = 3'd2;
    localparam t_cfg_idx CFG_REMOVE_BY_AREA  = 3'd3;
    localparam t_cfg_idx CFG_AREA_EPS_SQ     = 3'd4;

    // points and the unused code share the default path
    typedef logic [1:0] t_prim_mode;
    localparam t_prim_mode PRIM_LINES = 2'd1;
    localparam t_prim_mode PRIM_TRIS  = 2'd2;

    typedef logic [1:0] t_reason;
    localparam t_reason REASON_KEEP    = 2'd0;
    localparam t_reason REASON_INVALID = 2'd1;
    localparam t_reason REASON_REPEAT  = 2'd2;
    localparam t_reason REASON_AREA    = 2'd3;

    localparam logic ITEM_VERTEX = 1'b0;
    localparam logic ITEM_PRIM   = 1'b1;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

>>> rtl/triangle_cull_filter.sv
// channel    dir  handshake                      payload
// s_axis     in   s_axis_tvalid / s_axis_tready  vertex write or primitive submit
// m_axis     out  m_axis_tvalid / m_axis_tready  one word per primitive
// cfg        in   i_cfg_we                       register index and value
//
// a vertex word to a slot below the store depth is written as it is accepted; a slot at or
// beyond the depth is first reduced by shifted compare-subtract steps, then written.
// points, lines and triangles settled by index tests go through a check and an emit state.
// a triangle with the area test makes three reads of the single-port vertex store, then
// 15 multiplies on one shared multiplier, each a multiply state then an accumulate state.
// active-low synchronous reset sets control and config to defaults, clears drop counters.
// a result waits in the output register; the next word is accepted meanwhile.

`include "triangle_cull_filter_defines.svh"

module triangle_cull_filter #(
    parameter int VERTEX_DEPTH = tcf_pkg::DEF_VERTEX_DEPTH,
    parameter int POS_BITS     = tcf_pkg::DEF_POS_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // vertex_slot, pos_x, pos_y, pos_z, idx_a, idx_b, idx_c, zero pad
    input  logic [tcf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode
    input  logic [tcf_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_a, out_b, out_c, total_invalid, total_same_index, total_small_area
    output logic [tcf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // kept, drop_reason
    output logic [tcf_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tcf_pkg::*;

    localparam int AW   = $clog2(VERTEX_DEPTH);
    localparam int PW   = POS_BITS;
    localparam int VW   = 3 * PW;
    localparam int DW   = PW + 1;
    localparam int CW   = 2 * PW + 2;
    localparam int MAGW = 2 * PW + 1;
    localparam int LB   = PW + 1;
    localparam int MW   = PW + 2;
    localparam int PRW  = 2 * MW;
    localparam int SW   = 4 * PW + 4;
    localparam int CMPW = (SW > EPS_W) ? SW : EPS_W;
    localparam int KMAX = (AW >= SLOT_W) ? 0 : SLOT_W - AW;
    localparam int KW   = $clog2(SLOT_W + 1);
    localparam logic [31:0]   DEPTH32 = 32'(VERTEX_DEPTH);
    localparam logic [KW-1:0] KMAX_K  = KW'(KMAX);

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_WR, S_CHECK, S_RDA, S_RDB, S_RDC,
        S_XMUL, S_XACC, S_MAG, S_SMUL, S_SACC, S_CMP, S_EMIT
    } t_state;

    function automatic logic [PW-1:0] pos_fit(input logic [POS_IN_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[PW-1:0];
    endfunction

    // config registers
    t_prim_mode          r_prim_mode;
    logic [VC_W-1:0]     r_vcount;
    logic                r_rm_idx;
    logic                r_rm_area;
    logic [EPS_W-1:0]    r_eps;

    t_state              r_state;
    logic [SLOT_W-1:0]   r_slot;
    logic [VW-1:0]       r_pos;
    logic [KW-1:0]       r_k;
    logic [IDX_W-1:0]    r_a, r_b, r_c;
    logic                r_tri, r_line, r_vc_nz;
    t_reason             r_reason;
    logic [VW-1:0]       r_va;
    logic signed [DW-1:0] r_ab [3];
    logic signed [DW-1:0] r_ac [3];
    logic [2:0]          r_op;
    logic [1:0]          r_comp, r_piece;
    logic signed [PRW-1:0] r_prod;
    logic signed [CW-1:0]  r_cr [3];
    logic [SW-1:0]       r_sum;
    logic [CNT_W-1:0]    r_cnt_inv, r_cnt_same, r_cnt_small;
    logic [CNT_W-1:0]    n_cnt_inv, n_cnt_same, n_cnt_small;

    logic                r_out_valid, r_out_kept;
    t_reason             r_out_reason;
    logic [IDX_W-1:0]    r_out_a, r_out_b, r_out_c;
    logic [CNT_W-1:0]    r_out_inv, r_out_same, r_out_small;

    // vertex store
    logic [VW-1:0]       mem [VERTEX_DEPTH];
    logic [VW-1:0]       r_rd;
    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic [VW-1:0]       mem_wdata;

    // input unpacking
    logic                in_mode;
    logic [SLOT_W-1:0]   in_slot;
    logic [VW-1:0]       in_pos;
    logic [IDX_W-1:0]    in_a, in_b, in_c;
    logic [31:0]         slot_ext, r_slot_ext, mod_sub;
    logic                slot_in_range;
    logic                in_tri, in_line;

    logic [31:0]         vc_lim;
    logic                vc_zero, idx_bad, idx_rep;
    logic signed [DW-1:0] d_new [3];
    logic signed [MW-1:0] mul_a, mul_b;
    logic [MAGW-1:0]     mag_sel;
    logic [LB-1:0]       mag_lo;
    logic [MAGW-LB-1:0]  mag_hi;
    logic signed [CW-1:0] prod_cr;
    logic [SW-1:0]       prod_u, sq_term;
    logic [CMPW-1:0]     sum_ext, eps_ext;
    logic                out_free, emit_fire;

    assign in_mode = s_axis_tuser[0];
    assign in_slot = s_axis_tdata[S_SLOT_LSB +: SLOT_W];
    assign in_pos  = {pos_fit(s_axis_tdata[S_POSZ_LSB +: POS_IN_W]),
                      pos_fit(s_axis_tdata[S_POSY_LSB +: POS_IN_W]),
                      pos_fit(s_axis_tdata[S_POSX_LSB +: POS_IN_W])};
    assign in_a    = s_axis_tdata[S_IDXA_LSB +: IDX_W];
    assign in_b    = s_axis_tdata[S_IDXB_LSB +: IDX_W];
    assign in_c    = s_axis_tdata[S_IDXC_LSB +: IDX_W];
    assign in_tri  = (r_prim_mode == PRIM_TRIS);
    assign in_line = (r_prim_mode == PRIM_LINES);

    assign slot_ext      = 32'(in_slot);
    assign r_slot_ext    = 32'(r_slot);
    assign slot_in_range = (slot_ext < DEPTH32);
    assign mod_sub       = DEPTH32 << r_k;

    assign s_axis_tready = (r_state == S_IDLE);

    // index tests
    assign vc_lim  = (32'(r_vcount) > DEPTH32) ? DEPTH32 : 32'(r_vcount);
    assign vc_zero = (vc_lim == '0);
    assign idx_bad = (r_a >= vc_lim) || ((r_tri || r_line) && (r_b >= vc_lim))
                     || (r_tri && (r_c >= vc_lim));
    assign idx_rep = r_rm_idx && ((r_line && (r_a == r_b))
                     || (r_tri && ((r_a == r_b) || (r_b == r_c) || (r_c == r_a))));

    // store port
    assign mem_we = (r_state == S_WR) || ((r_state == S_IDLE) && s_axis_tvalid
                    && (in_mode == ITEM_VERTEX) && slot_in_range);
    assign mem_wdata = (r_state == S_WR) ? r_pos : in_pos;

    always_comb begin
        case (r_state)
            S_IDLE:  mem_addr = slot_ext[AW-1:0];
            S_WR:    mem_addr = r_slot_ext[AW-1:0];
            S_CHECK: mem_addr = r_a[AW-1:0];
            S_RDA:   mem_addr = r_b[AW-1:0];
            S_RDB:   mem_addr = r_c[AW-1:0];
            default: mem_addr = r_a[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rd <= mem[mem_addr];
    end

    // edge vectors from the word just read against vertex a
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_new[k] = DW'(signed'(r_rd[k*PW +: PW])) - DW'(signed'(r_va[k*PW +: PW]));
        end
    end

    // shared multiplier operands
    assign mag_sel = r_cr[r_comp][MAGW-1:0];
    assign mag_lo  = mag_sel[LB-1:0];
    assign mag_hi  = mag_sel[MAGW-1:LB];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_SMUL) begin
            case (r_piece)
                2'd1: begin
                    mul_a = signed'(MW'(mag_hi));
                    mul_b = signed'(MW'(mag_lo));
                end
                2'd2: begin
                    mul_a = signed'(MW'(mag_hi));
                    mul_b = signed'(MW'(mag_hi));
                end
                default: begin
                    mul_a = signed'(MW'(mag_lo));
                    mul_b = signed'(MW'(mag_lo));
                end
            endcase
        end else begin
            // cross product terms, each pair subtracted into one component
            case (r_op)
                3'd0: begin mul_a = MW'(r_ab[1]); mul_b = MW'(r_ac[2]); end
                3'd1: begin mul_a = MW'(r_ab[2]); mul_b = MW'(r_ac[1]); end
                3'd2: begin mul_a = MW'(r_ab[2]); mul_b = MW'(r_ac[0]); end
                3'd3: begin mul_a = MW'(r_ab[0]); mul_b = MW'(r_ac[2]); end
                3'd4: begin mul_a = MW'(r_ab[0]); mul_b = MW'(r_ac[1]); end
                3'd5: begin mul_a = MW'(r_ab[1]); mul_b = MW'(r_ac[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign prod_cr = CW'(r_prod);
    assign prod_u  = SW'(unsigned'(r_prod));

    // square of a magnitude split as hi*2^LB + lo
    always_comb begin
        case (r_piece)
            2'd1:    sq_term = prod_u << (LB + 1);
            2'd2:    sq_term = prod_u << (2 * LB);
            default: sq_term = prod_u;
        endcase
    end

    assign sum_ext = CMPW'(r_sum);
    assign eps_ext = CMPW'(r_eps);

    assign out_free  = !r_out_valid || m_axis_tready;
    assign emit_fire = (r_state == S_EMIT) && out_free;

    assign n_cnt_inv   = (emit_fire && (r_reason == REASON_INVALID) && r_tri && r_vc_nz)
                         ? sat_inc(r_cnt_inv) : r_cnt_inv;
    assign n_cnt_same  = (emit_fire && (r_reason == REASON_REPEAT))
                         ? sat_inc(r_cnt_same) : r_cnt_same;
    assign n_cnt_small = (emit_fire && (r_reason == REASON_AREA))
                         ? sat_inc(r_cnt_small) : r_cnt_small;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prim_mode <= PRIM_TRIS;
            r_vcount    <= '0;
            r_rm_idx    <= 1'b1;
            r_rm_area   <= 1'b1;
            r_eps       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRIM_MODE:       r_prim_mode <= i_cfg_data[1:0];
                CFG_VERTEX_COUNT:    r_vcount    <= i_cfg_data[VC_W-1:0];
                CFG_REMOVE_BY_INDEX: r_rm_idx    <= i_cfg_data[0];
                CFG_REMOVE_BY_AREA:  r_rm_area   <= i_cfg_data[0];
                CFG_AREA_EPS_SQ:     r_eps       <= i_cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt_inv   <= '0;
            r_cnt_same  <= '0;
            r_cnt_small <= '0;
        end else begin
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_cnt_inv   <= n_cnt_inv;
            r_cnt_same  <= n_cnt_same;
            r_cnt_small <= n_cnt_small;

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (in_mode == ITEM_PRIM) begin
                            r_a     <= in_a;
                            r_b     <= (in_tri || in_line) ? in_b : '0;
                            r_c     <= in_tri ? in_c : '0;
                            r_tri   <= in_tri;
                            r_line  <= in_line;
                            r_state <= S_CHECK;
                        end else if (!slot_in_range) begin
                            r_slot  <= in_slot;
                            r_pos   <= in_pos;
                            r_k     <= KMAX_K;
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    // remainder by the store depth, one shifted subtract per cycle
                    if (r_slot_ext >= mod_sub) begin
                        r_slot <= r_slot - mod_sub[SLOT_W-1:0];
                    end
                    if (r_k == '0) begin
                        r_state <= S_WR;
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end
                S_WR: begin
                    r_state <= S_IDLE;
                end
                S_CHECK: begin
                    r_vc_nz <= !vc_zero;
                    if (vc_zero || idx_bad) begin
                        r_reason <= REASON_INVALID;
                        r_state  <= S_EMIT;
                    end else if (idx_rep) begin
                        r_reason <= REASON_REPEAT;
                        r_state  <= S_EMIT;
                    end else if (r_tri && r_rm_area) begin
                        r_reason <= REASON_KEEP;
                        r_state  <= S_RDA;
                    end else begin
                        r_reason <= REASON_KEEP;
                        r_state  <= S_EMIT;
                    end
                end
                S_RDA: begin
                    r_va    <= r_rd;
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    for (int k = 0; k < 3; k++) begin
                        r_ab[k] <= d_new[k];
                    end
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    for (int k = 0; k < 3; k++) begin
                        r_ac[k] <= d_new[k];
                    end
                    r_op    <= '0;
                    r_state <= S_XMUL;
                end
                S_XMUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_XACC;
                end
                S_XACC: begin
                    if (!r_op[0]) begin
                        r_cr[r_op[2:1]] <= prod_cr;
                    end else begin
                        r_cr[r_op[2:1]] <= r_cr[r_op[2:1]] - prod_cr;
                    end
                    if (r_op == 3'd5) begin
                        r_state <= S_MAG;
                    end else begin
                        r_op    <= r_op + 1'b1;
                        r_state <= S_XMUL;
                    end
                end
                S_MAG: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_cr[k][CW-1]) begin
                            r_cr[k] <= -r_cr[k];
                        end
                    end
                    r_sum   <= '0;
                    r_comp  <= '0;
                    r_piece <= '0;
                    r_state <= S_SMUL;
                end
                S_SMUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_SACC;
                end
                S_SACC: begin
                    r_sum <= r_sum + sq_term;
                    if (r_piece == 2'd2) begin
                        r_piece <= '0;
                        if (r_comp == 2'd2) begin
                            r_state <= S_CMP;
                        end else begin
                            r_comp  <= r_comp + 1'b1;
                            r_state <= S_SMUL;
                        end
                    end else begin
                        r_piece <= r_piece + 1'b1;
                        r_state <= S_SMUL;
                    end
                end
                S_CMP: begin
                    if (sum_ext <= eps_ext) begin
                        r_reason <= REASON_AREA;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_kept   <= (r_reason == REASON_KEEP);
                        r_out_reason <= r_reason;
                        r_out_a      <= r_a;
                        r_out_b      <= r_b;
                        r_out_c      <= r_c;
                        r_out_inv    <= n_cnt_inv;
                        r_out_same   <= n_cnt_same;
                        r_out_small  <= n_cnt_small;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_small, r_out_same, r_out_inv, r_out_c, r_out_b, r_out_a};
    assign m_axis_tuser  = {r_out_reason, r_out_kept};

    `TCF_ASSERT_NEXT(a_one_counter_step, i_clk, i_rst_n, 1'b1, ($countones({(r_cnt_inv != $past(r_cnt_inv)), (r_cnt_same != $past(r_cnt_same)), (r_cnt_small != $past(r_cnt_small))}) <= 1), "more than one drop counter moved in a cycle")
    `TCF_ASSERT_NEXT(a_count_on_emit, i_clk, i_rst_n, 1'b1, (((r_cnt_inv == $past(r_cnt_inv)) && (r_cnt_same == $past(r_cnt_same)) && (r_cnt_small == $past(r_cnt_small))) || $past(emit_fire)), "drop counter moved without a result")
    `TCF_ASSERT_NOW(a_area_only_tris, i_clk, i_rst_n, (emit_fire && (r_reason == REASON_AREA)), r_tri, "area drop on a non-triangle")

endmodule

>>> tb/cull_checker.sv
module cull_checker
    import tcf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // vertex_slot, pos_x, pos_y, pos_z, idx_a, idx_b, idx_c, zero pad
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // mode
    input  logic [S_TUSER_W-1:0]   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_a, out_b, out_c, total_invalid, total_same_index, total_small_area
    input  logic [M_TDATA_W-1:0]   m_axis_tdata,
    // kept, drop_reason
    input  logic [M_TUSER_W-1:0]   m_axis_tuser,
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int unsigned            o_mismatches,
    output int unsigned            o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VDEPTH = DEF_VERTEX_DEPTH;

    typedef struct {
        logic             kept;
        t_reason          reason;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic [CNT_W-1:0] n_invalid;
        logic [CNT_W-1:0] n_repeat;
        logic [CNT_W-1:0] n_area;
    } cull_word_t;

    // shadow of the block's registers and state
    t_prim_mode             prim_mode;
    logic [VC_W-1:0]        vertex_count;
    logic                   drop_repeats;
    logic                   drop_small;
    logic [EPS_W-1:0]       area_eps;
    logic signed [POS_IN_W-1:0] pos_x [VDEPTH];
    logic signed [POS_IN_W-1:0] pos_y [VDEPTH];
    logic signed [POS_IN_W-1:0] pos_z [VDEPTH];
    logic [CNT_W-1:0]       cnt_invalid;
    logic [CNT_W-1:0]       cnt_repeat;
    logic [CNT_W-1:0]       cnt_area;

    cull_word_t  verdicts_due[$];
    int unsigned n_bad;

    assign o_mismatches = n_bad;

    function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [127:0] square_wide(longint v);
        logic [63:0] mg;
        mg = (v < 0) ? -v : v;
        return {64'd0, mg} * {64'd0, mg};
    endfunction

    // decides one primitive and updates the drop counters
    function automatic cull_word_t judge_primitive(logic [IDX_W-1:0] ia, ib, ic);
        cull_word_t v;
        logic tri_m, line_m;
        logic [IDX_W-1:0] lim;
        logic [SLOT_W-1:0] sa, sb, sc;
        longint abx, aby, abz, acx, acy, acz, cx, cy, cz;
        logic [127:0] cross_sq;
        tri_m  = (prim_mode == PRIM_TRIS);
        line_m = (prim_mode == PRIM_LINES);
        lim = (vertex_count > VDEPTH) ? VDEPTH : vertex_count;
        v.a = ia;
        v.b = (tri_m || line_m) ? ib : '0;
        v.c = tri_m ? ic : '0;
        v.reason = REASON_KEEP;
        if (lim == 0) begin
            v.reason = REASON_INVALID;
        end else if (v.a >= lim || ((tri_m || line_m) && v.b >= lim) || (tri_m && v.c >= lim)) begin
            v.reason = REASON_INVALID;
            if (tri_m) cnt_invalid = sat_bump(cnt_invalid);
        end else if (line_m) begin
            if (drop_repeats && v.a == v.b) begin
                v.reason = REASON_REPEAT;
                cnt_repeat = sat_bump(cnt_repeat);
            end
        end else if (tri_m) begin
            if (drop_repeats && (v.a == v.b || v.b == v.c || v.c == v.a)) begin
                v.reason = REASON_REPEAT;
                cnt_repeat = sat_bump(cnt_repeat);
            end else if (drop_small) begin
                sa = v.a[SLOT_W-1:0];
                sb = v.b[SLOT_W-1:0];
                sc = v.c[SLOT_W-1:0];
                abx = longint'(pos_x[sb]) - longint'(pos_x[sa]);
                aby = longint'(pos_y[sb]) - longint'(pos_y[sa]);
                abz = longint'(pos_z[sb]) - longint'(pos_z[sa]);
                acx = longint'(pos_x[sc]) - longint'(pos_x[sa]);
                acy = longint'(pos_y[sc]) - longint'(pos_y[sa]);
                acz = longint'(pos_z[sc]) - longint'(pos_z[sa]);
                cx = aby * acz - abz * acy;
                cy = abz * acx - abx * acz;
                cz = abx * acy - aby * acx;
                // exact, up to 68 bits
                cross_sq = square_wide(cx) + square_wide(cy) + square_wide(cz);
                if (cross_sq <= {64'd0, area_eps}) begin
                    v.reason = REASON_AREA;
                    cnt_area = sat_bump(cnt_area);
                end
            end
        end
        v.kept = (v.reason == REASON_KEEP);
        v.n_invalid = cnt_invalid;
        v.n_repeat  = cnt_repeat;
        v.n_area    = cnt_area;
        return v;
    endfunction

    always @(posedge i_clk) begin
        cull_word_t want, got;
        if (!i_rst_n) begin
            prim_mode    = PRIM_TRIS;
            vertex_count = '0;
            drop_repeats = 1'b1;
            drop_small   = 1'b1;
            area_eps     = '0;
            cnt_invalid  = '0;
            cnt_repeat   = '0;
            cnt_area     = '0;
            n_bad        = 0;
            verdicts_due.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == ITEM_VERTEX) begin
                    pos_x[s_axis_tdata[S_SLOT_LSB +: SLOT_W]] = s_axis_tdata[S_POSX_LSB +: POS_IN_W];
                    pos_y[s_axis_tdata[S_SLOT_LSB +: SLOT_W]] = s_axis_tdata[S_POSY_LSB +: POS_IN_W];
                    pos_z[s_axis_tdata[S_SLOT_LSB +: SLOT_W]] = s_axis_tdata[S_POSZ_LSB +: POS_IN_W];
                end else begin
                    verdicts_due.push_back(judge_primitive(s_axis_tdata[S_IDXA_LSB +: IDX_W],
                                                           s_axis_tdata[S_IDXB_LSB +: IDX_W],
                                                           s_axis_tdata[S_IDXC_LSB +: IDX_W]));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kept      = m_axis_tuser[0];
                got.reason    = m_axis_tuser[2:1];
                got.a         = m_axis_tdata[31:0];
                got.b         = m_axis_tdata[63:32];
                got.c         = m_axis_tdata[95:64];
                got.n_invalid = m_axis_tdata[127:96];
                got.n_repeat  = m_axis_tdata[159:128];
                got.n_area    = m_axis_tdata[191:160];
                if (verdicts_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch at %0t: result word with none expected", $realtime);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.kept !== want.kept || got.reason !== want.reason ||
                        got.a !== want.a || got.b !== want.b || got.c !== want.c ||
                        got.n_invalid !== want.n_invalid || got.n_repeat !== want.n_repeat ||
                        got.n_area !== want.n_area) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("mismatch at %0t: want kept=%0b reason=%0d idx=%0h/%0h/%0h cnt=%0d/%0d/%0d",
                                     $realtime, want.kept, want.reason, want.a, want.b, want.c,
                                     want.n_invalid, want.n_repeat, want.n_area);
                            $display("    got kept=%0b reason=%0d idx=%0h/%0h/%0h cnt=%0d/%0d/%0d",
                                     got.kept, got.reason, got.a, got.b, got.c,
                                     got.n_invalid, got.n_repeat, got.n_area);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PRIM_MODE:       prim_mode    = i_cfg_data[1:0];
                    CFG_VERTEX_COUNT:    vertex_count = i_cfg_data[VC_W-1:0];
                    CFG_REMOVE_BY_INDEX: drop_repeats = i_cfg_data[0];
                    CFG_REMOVE_BY_AREA:  drop_small   = i_cfg_data[0];
                    CFG_AREA_EPS_SQ:     area_eps     = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_outstanding <= verdicts_due.size();
    end

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcf_pkg::*;

    localparam int          DEPTH        = DEF_VERTEX_DEPTH;
    localparam int          QUIET_CYCLES = 60;
    localparam int          LONG_HOLD    = 300;
    localparam int          RAND_PHASES  = 12;
    localparam int          PHASE_ITEMS  = 66;
    localparam t_prim_mode  PRIM_POINTS  = 2'd0;
    localparam t_prim_mode  PRIM_OTHER   = 2'd3;
    localparam logic [63:0] EPS_ALL      = '1;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // vertex_slot, pos_x, pos_y, pos_z, idx_a, idx_b, idx_c, zero pad
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    // mode
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // out_a, out_b, out_c, total_invalid, total_same_index, total_small_area
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // kept, drop_reason
    logic [M_TUSER_W-1:0]  m_axis_tuser;
    logic                  i_cfg_we      = 1'b0;
    t_cfg_idx              i_cfg_idx     = CFG_PRIM_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int unsigned n_mismatch;
    int unsigned n_outstanding;
    int unsigned cur_lim;
    t_prim_mode  cur_mode;
    int          burst_left = 0;
    logic        long_hold_req = 1'b0;
    logic        long_hold_done = 1'b0;

    always #5 i_clk = ~i_clk;

    triangle_cull_filter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    cull_checker i_cull_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (n_mismatch),
        .o_outstanding (n_outstanding)
    );

    // offers one word, waits for the handshake, then maybe a gap between bursts
    task automatic send_word(logic mode, logic [SLOT_W-1:0] slot, logic [15:0] x, y, z,
                             logic [IDX_W-1:0] a, b, c);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'd0, c, b, a, z, y, x, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // unused index fields carry noise so every bit gets exercised
    task automatic put_vertex(logic [SLOT_W-1:0] slot, logic [15:0] x, y, z);
        send_word(ITEM_VERTEX, slot, x, y, z, $urandom, $urandom, $urandom);
    endtask

    task automatic submit_prim(logic [IDX_W-1:0] a, b, c);
        send_word(ITEM_PRIM, 12'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  a, b, c);
    endtask

    // drain everything, then give a long triangle time to finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (n_outstanding != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(t_prim_mode pm, logic [VC_W-1:0] vc, logic rbi, rba,
                               logic [EPS_W-1:0] eps);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PRIM_MODE;
        i_cfg_data <= 64'(pm);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_VERTEX_COUNT;
        i_cfg_data <= 64'(vc);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_REMOVE_BY_INDEX;
        i_cfg_data <= 64'(rbi);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_REMOVE_BY_AREA;
        i_cfg_data <= 64'(rba);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_AREA_EPS_SQ;
        i_cfg_data <= eps;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_mode = pm;
        cur_lim  = (vc > DEPTH) ? DEPTH : vc;
    endtask

    function automatic logic [IDX_W-1:0] pick_index(int unsigned lim);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (lim != 0 && r < 7) return $urandom_range(0, lim - 1);
        case (r)
            7:       return lim;
            8:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // receiver: runs of one ready pattern, plus one long hold-off on request
    initial begin : sink
        int style, run;
        forever begin
            if (long_hold_req && !long_hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            style = $urandom_range(0, 3);
            run   = $urandom_range(1, 40);
            repeat (run) begin
                case (style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int ph, sent, k, r, shape, bx, by, bz, dx, dy, dz, m;
        int px[3], py[3], pz[3];
        int unsigned lim;
        logic [SLOT_W-1:0] sl[3];
        logic [IDX_W-1:0] ia, ib, ic;
        logic [VC_W-1:0] vc;
        logic [EPS_W-1:0] eps;
        t_prim_mode pm;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: zero vertex count drops everything, counters stay
        submit_prim(0, 1, 2);
        // fill the whole store so no primitive ever reads an unwritten slot
        for (k = 0; k < DEPTH; k++)
            put_vertex(k, 16'($urandom), 16'($urandom), 16'($urandom));
        settle();

        load_config(PRIM_TRIS, DEPTH, 1'b1, 1'b1, '0);
        put_vertex(0, 16'h8000, 16'h8000, 16'h8000);
        put_vertex(4095, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        put_vertex(1, 16'h7FFF, 16'h8000, 16'h0000);
        // collinear
        put_vertex(2, 0, 0, 0);
        put_vertex(3, 1, 1, 1);
        put_vertex(4, 2, 2, 2);
        // unit right triangle, squared cross length of one
        put_vertex(5, 0, 0, 0);
        put_vertex(6, 1, 0, 0);
        put_vertex(7, 0, 1, 0);
        submit_prim(0, 4095, 1);
        submit_prim(2, 3, 4);
        submit_prim(5, 6, 7);
        submit_prim(0, 0, 1);
        submit_prim(1, 4095, 1);
        submit_prim(4096, 0, 1);
        submit_prim(0, 1, 32'hFFFF_FFFF);
        // invalid wins over repeated
        submit_prim(4096, 4096, 0);
        settle();

        // count above depth saturates, threshold is inclusive
        load_config(PRIM_TRIS, 13'h1FFF, 1'b0, 1'b1, 64'd1);
        submit_prim(5, 6, 7);
        submit_prim(0, 0, 1);
        submit_prim(4096, 1, 2);
        submit_prim(3, 4, 4095);
        settle();

        load_config(PRIM_LINES, 1, 1'b1, 1'b0, EPS_ALL);
        submit_prim(0, 0, 5);
        submit_prim(0, 1, 5);
        submit_prim(32'hFFFF_FFFF, 0, 5);
        settle();

        load_config(PRIM_POINTS, DEPTH, 1'b1, 1'b1, '0);
        submit_prim(4095, 7, 7);
        submit_prim(4096, 7, 7);
        settle();

        load_config(PRIM_OTHER, 2, 1'b0, 1'b0, '0);
        submit_prim(1, 1, 1);
        submit_prim(2, 0, 0);
        settle();

        load_config(PRIM_TRIS, DEPTH, 1'b0, 1'b0, EPS_ALL);
        submit_prim(2, 3, 4);
        submit_prim(0, 0, 0);
        settle();

        // cross length just above 64 bits survives the widest threshold
        load_config(PRIM_TRIS, DEPTH, 1'b1, 1'b1, EPS_ALL);
        submit_prim(5, 6, 7);
        submit_prim(0, 4095, 1);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            case ($urandom_range(0, 7))
                0:       vc = 0;
                1:       vc = 1;
                2:       vc = $urandom_range(2, 16);
                3, 4:    vc = DEPTH;
                5:       vc = $urandom_range(DEPTH + 1, 8191);
                6:       vc = 13'h1FFF;
                default: vc = $urandom_range(1, DEPTH - 1);
            endcase
            case ($urandom_range(0, 5))
                0:       eps = '0;
                1:       eps = $urandom_range(0, 300);
                2:       eps = $urandom_range(0, 5000);
                3:       eps = EPS_ALL;
                4:       eps = {$urandom, $urandom};
                default: eps = 64'd1 << $urandom_range(0, 63);
            endcase
            pm = ($urandom_range(0, 9) < 6) ? PRIM_TRIS : t_prim_mode'($urandom_range(0, 3));
            load_config(pm, vc, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, eps);
            if (ph == 2) long_hold_req = 1'b1;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 55 && cur_mode == PRIM_TRIS) begin
                    // write three vertices, then a triangle over them
                    lim = (cur_lim == 0) ? DEPTH : cur_lim;
                    for (k = 0; k < 3; k++) sl[k] = $urandom_range(0, lim - 1);
                    if ($urandom_range(0, 9) == 0) sl[1] = sl[0];
                    bx = int'($urandom_range(0, 60000)) - 30000;
                    by = int'($urandom_range(0, 60000)) - 30000;
                    bz = int'($urandom_range(0, 60000)) - 30000;
                    dx = int'($urandom_range(0, 8)) - 4;
                    dy = int'($urandom_range(0, 8)) - 4;
                    dz = int'($urandom_range(0, 8)) - 4;
                    shape = $urandom_range(0, 3);
                    for (k = 0; k < 3; k++) begin
                        case (shape)
                            0, 2: begin
                                px[k] = bx + int'($urandom_range(0, 16)) - 8;
                                py[k] = by + int'($urandom_range(0, 16)) - 8;
                                pz[k] = bz + int'($urandom_range(0, 16)) - 8;
                                // a repeated position gives zero area
                                if (shape == 2 && k == 2) begin
                                    px[2] = px[0];
                                    py[2] = py[0];
                                    pz[2] = pz[0];
                                end
                            end
                            1: begin
                                m = int'($urandom_range(0, 6)) - 3;
                                px[k] = bx + m * dx;
                                py[k] = by + m * dy;
                                pz[k] = bz + m * dz;
                            end
                            default: begin
                                px[k] = int'($urandom_range(0, 65535)) - 32768;
                                py[k] = int'($urandom_range(0, 65535)) - 32768;
                                pz[k] = int'($urandom_range(0, 65535)) - 32768;
                            end
                        endcase
                        put_vertex(sl[k], 16'(px[k]), 16'(py[k]), 16'(pz[k]));
                    end
                    ia = sl[0];
                    ib = sl[1];
                    ic = sl[2];
                    if ($urandom_range(0, 9) == 0) ic = pick_index(cur_lim);
                    submit_prim(ia, ib, ic);
                    sent += 4;
                end else if (r < 80) begin
                    ia = pick_index(cur_lim);
                    ib = ($urandom_range(0, 6) == 0) ? ia : pick_index(cur_lim);
                    case ($urandom_range(0, 7))
                        0:       ic = ia;
                        1:       ic = ib;
                        default: ic = pick_index(cur_lim);
                    endcase
                    submit_prim(ia, ib, ic);
                    sent++;
                end else begin
                    put_vertex(12'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                    sent++;
                end
            end
        end

        settle();
        if (n_mismatch == 0 && n_outstanding == 0)
            $display("PASS triangle_cull_filter");
        else
            $display("FAIL triangle_cull_filter");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAIL triangle_cull_filter");
        $finish;
    end

endmodule
